FILE: src/ibqs_pkg.sv
package ibqs_pkg;

    // Store geometry
    localparam int SLOTS   = 128;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int CHILD_W = SLOT_W + 2;
    localparam int COUNT_W = $clog2(SLOTS + 1);

    // Field widths
    localparam int OP_W     = 2;
    localparam int KEY_W    = 16;
    localparam int AMT_W    = 31;
    localparam int STATUS_W = 3;
    localparam int INDEX_W  = 7;

    localparam logic [AMT_W-1:0] AMT_MAX = {AMT_W{1'b1}};

    // Opcodes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_TAKE   = 2'd1;
    localparam logic [OP_W-1:0] OP_ADD    = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd1;
    localparam logic [STATUS_W-1:0] ST_SHORT    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SAT      = 3'd4;

    // One stored entry
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [AMT_W-1:0] amount;
        logic [AMT_W-1:0] price;
    } slot_word_t;

    // Access request from the walker to the slot store
    typedef struct packed {
        logic [SLOT_W-1:0] rd_addr;
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
        slot_word_t        wr_word;
    } store_req_t;

    // Registered read response, valid in the cycle after the request
    typedef struct packed {
        logic       valid;
        slot_word_t word;
    } store_rsp_t;

    // One result item
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [AMT_W-1:0]    remaining;
        logic [AMT_W-1:0]    stored_price;
        logic [INDEX_W-1:0]  slot_index;
    } result_t;

endpackage

FILE: src/implicit_bst_quantity_store_unit.sv
// Key/quantity store organized as a binary search tree in a slot array.
//
// Input channel (s_valid/s_ready): one request carries an opcode (insert,
// take, add), a 16-bit key, a quantity and a unit price. The result channel
// (m_valid/m_ready) returns exactly one item per request: status, remaining
// amount, stored price and slot index.
//
// Walk: the sequencer reads one tree level per cycle through the single
// registered read port of the slot memory, from the root (level 1) down;
// the lone eighth-level slot of a 128-slot store is the deepest a walk can
// reach. Requests that finish without a walk (empty store, full store,
// unused opcode) go from acceptance straight to the result.
// One request is in flight at a time; the next is accepted once the result
// has moved into the output register.
//
// Reset (aresetn low, synchronous) empties the store at once: occupancy bits
// and the entry count clear, no sweep is needed.
// When the receiver stalls, the result holds in the output register; one
// more request may complete behind it and then waits until it drains.
module implicit_bst_quantity_store_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [ibqs_pkg::OP_W-1:0]          s_opcode,
    input  logic [ibqs_pkg::KEY_W-1:0]         s_key,
    input  logic [ibqs_pkg::AMT_W-1:0]         s_quantity,
    input  logic [ibqs_pkg::AMT_W-1:0]         s_unit_price,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [ibqs_pkg::STATUS_W-1:0]      m_status,
    output logic [ibqs_pkg::AMT_W-1:0]         m_remaining,
    output logic [ibqs_pkg::AMT_W-1:0]         m_stored_price,
    output logic [ibqs_pkg::INDEX_W-1:0]       m_slot_index
);
    import ibqs_pkg::*;

    store_req_t req;
    store_rsp_t rsp;
    result_t    res;
    logic       res_valid;
    logic       res_ready;
    logic       m_valid_reg;
    result_t    out_reg;

    ibqs_slot_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .rsp     (rsp)
    );

    ibqs_walk_ctrl u_walk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_valid),
        .in_ready      (s_ready),
        .in_opcode     (s_opcode),
        .in_key        (s_key),
        .in_quantity   (s_quantity),
        .in_unit_price (s_unit_price),
        .req           (req),
        .rsp           (rsp),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res)
    );

    // Load the output register when empty or draining
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = out_reg.status;
    assign m_remaining    = out_reg.remaining;
    assign m_stored_price = out_reg.stored_price;
    assign m_slot_index   = out_reg.slot_index;

endmodule

FILE: src/ibqs_slot_store.sv
module ibqs_slot_store (
    input  logic                aclk,
    input  logic                aresetn,
    input  ibqs_pkg::store_req_t req,
    output ibqs_pkg::store_rsp_t rsp
);
    import ibqs_pkg::*;

    slot_word_t        slot_mem [SLOTS];
    logic [SLOTS-1:0]  valid_reg;
    slot_word_t        rd_word_reg;
    logic              rd_valid_reg;

    // Write port and registered read of the entry payload
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            slot_mem[req.wr_addr] <= req.wr_word;
        end
        rd_word_reg <= slot_mem[req.rd_addr];
    end

    // Occupancy bits: cleared by reset, set on every write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (req.wr_en) begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[req.rd_addr];
        end
    end

    assign rsp.valid = rd_valid_reg;
    assign rsp.word  = rd_word_reg;

endmodule

FILE: src/ibqs_walk_ctrl.sv
module ibqs_walk_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ibqs_pkg::OP_W-1:0]     in_opcode,
    input  logic [ibqs_pkg::KEY_W-1:0]    in_key,
    input  logic [ibqs_pkg::AMT_W-1:0]    in_quantity,
    input  logic [ibqs_pkg::AMT_W-1:0]    in_unit_price,
    output ibqs_pkg::store_req_t          req,
    input  ibqs_pkg::store_rsp_t          rsp,
    output logic                          res_valid,
    input  logic                          res_ready,
    output ibqs_pkg::result_t             res
);
    import ibqs_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]         state_reg,   state_next;
    logic [OP_W-1:0]    op_reg,      op_next;
    logic [KEY_W-1:0]   key_reg,     key_next;
    logic [AMT_W-1:0]   qty_reg,     qty_next;
    logic [AMT_W-1:0]   price_reg,   price_next;
    logic [SLOT_W-1:0]  at_reg,      at_next;
    logic [COUNT_W-1:0] count_reg,   count_next;
    result_t            res_reg,     res_next;

    logic [CHILD_W-1:0] child;
    logic               child_in;
    logic               key_hit;
    logic [AMT_W:0]     sum;
    logic               in_fire;

    assign in_fire = in_valid && in_ready;

    // Child slot of the entry just read
    always_comb begin
        child = (CHILD_W'(at_reg) << 1)
              + ((key_reg < rsp.word.key) ? CHILD_W'(1) : CHILD_W'(2));
        child_in = child < CHILD_W'(SLOTS);
        key_hit  = rsp.word.key == key_reg;
        sum      = {1'b0, rsp.word.amount} + {1'b0, qty_reg};
    end

    // Walk sequencer: one tree level per cycle, any write-back on the last
    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        key_next   = key_reg;
        qty_next   = qty_reg;
        price_next = price_reg;
        at_next    = at_reg;
        count_next = count_reg;
        res_next   = res_reg;

        req.rd_addr = at_reg;
        req.wr_en   = 1'b0;
        req.wr_addr = at_reg;
        req.wr_word = rsp.word;

        case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    op_next    = in_opcode;
                    key_next   = in_key;
                    qty_next   = in_quantity;
                    price_next = in_unit_price;
                    at_next    = '0;
                    req.rd_addr = '0;
                    res_next   = '0;
                    if (in_opcode == OP_INSERT) begin
                        if (count_reg >= COUNT_W'(SLOTS)) begin
                            res_next.status = ST_FULL;
                            state_next      = S_DONE;
                        end else begin
                            state_next = S_WALK;
                        end
                    end else if (in_opcode == OP_TAKE || in_opcode == OP_ADD) begin
                        if (count_reg == '0) begin
                            res_next.status = ST_NOTFOUND;
                            state_next      = S_DONE;
                        end else begin
                            state_next = S_WALK;
                        end
                    end else begin
                        res_next.status = ST_NOTFOUND;
                        state_next      = S_DONE;
                    end
                end
            end

            S_WALK: begin
                res_next = '0;
                if (op_reg == OP_INSERT) begin
                    if (!rsp.valid) begin
                        // fill the empty slot
                        req.wr_en          = 1'b1;
                        req.wr_word.key    = key_reg;
                        req.wr_word.amount = qty_reg;
                        req.wr_word.price  = price_reg;
                        count_next         = count_reg + COUNT_W'(1);
                        res_next.status       = ST_OK;
                        res_next.remaining    = qty_reg;
                        res_next.stored_price = price_reg;
                        res_next.slot_index   = INDEX_W'(at_reg);
                        state_next            = S_DONE;
                    end else if (child_in) begin
                        req.rd_addr = child[SLOT_W-1:0];
                        at_next     = child[SLOT_W-1:0];
                        res_next    = res_reg;
                    end else begin
                        res_next.status = ST_FULL;
                        state_next      = S_DONE;
                    end
                end else begin
                    if (!rsp.valid) begin
                        res_next.status = ST_NOTFOUND;
                        state_next      = S_DONE;
                    end else if (key_hit) begin
                        res_next.stored_price = rsp.word.price;
                        res_next.slot_index   = INDEX_W'(at_reg);
                        state_next            = S_DONE;
                        if (op_reg == OP_TAKE) begin
                            if (qty_reg <= rsp.word.amount) begin
                                req.wr_en          = 1'b1;
                                req.wr_word.amount = rsp.word.amount - qty_reg;
                                res_next.status    = ST_OK;
                                res_next.remaining = rsp.word.amount - qty_reg;
                            end else begin
                                res_next.status    = ST_SHORT;
                                res_next.remaining = rsp.word.amount;
                            end
                        end else begin
                            req.wr_en = 1'b1;
                            if (sum[AMT_W]) begin
                                req.wr_word.amount = AMT_MAX;
                                res_next.status    = ST_SAT;
                                res_next.remaining = AMT_MAX;
                            end else begin
                                req.wr_word.amount = sum[AMT_W-1:0];
                                res_next.status    = ST_OK;
                                res_next.remaining = sum[AMT_W-1:0];
                            end
                        end
                    end else if (child_in) begin
                        req.rd_addr = child[SLOT_W-1:0];
                        at_next     = child[SLOT_W-1:0];
                        res_next    = res_reg;
                    end else begin
                        res_next.status = ST_NOTFOUND;
                        state_next      = S_DONE;
                    end
                end
            end

            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Request payload and result hold
    always_ff @(posedge aclk) begin
        op_reg    <= op_next;
        key_reg   <= key_next;
        qty_reg   <= qty_next;
        price_reg <= price_next;
        at_reg    <= at_next;
        res_reg   <= res_next;
    end

    assign in_ready  = state_reg == S_IDLE;
    assign res_valid = state_reg == S_DONE;
    assign res       = res_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_W'(SLOTS))
        else $error("entry count above slot count");

    a_write_in_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        req.wr_en |-> state_reg == S_WALK)
        else $error("store write outside the walk");

    a_write_ends_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        req.wr_en |=> state_reg == S_DONE)
        else $error("walk continued after write-back");

    a_miss_is_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && (res.status == ST_NOTFOUND || res.status == ST_FULL))
        |-> (res.remaining == '0 && res.slot_index == '0 && res.stored_price == '0))
        else $error("miss result carries entry data");

    a_count_on_insert: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WALK && req.wr_en && op_reg == OP_INSERT)
        |=> count_reg == $past(count_reg) + COUNT_W'(1))
        else $error("insert did not bump entry count");
`endif

endmodule
